// ===== rtl/tps_pkg.sv =====
package tps_pkg;

    localparam int PAGES = 256;
    localparam int IDX_W = $clog2(PAGES);
    localparam int REF_W = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W = 9;
    localparam int ADDR_W = 4;
    localparam int UW = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam logic [UW-1:0] PAGES_U = UW'(PAGES);

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_ORIGIN = 2'd1,
        REG_LIMIT  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
    } ram_rsp_t;

    // effective limit, min(unit_limit, PAGES)
    function automatic logic [UW-1:0] eff_limit(input logic [CNT_W-1:0] limit);
        logic [UW-1:0] l;
        l = UW'(limit);
        return (l > PAGES_U) ? PAGES_U : l;
    endfunction

    // used pages: highest seen plus one, clamped to the limit; zero while disabled
    function automatic logic [CNT_W-1:0] used_count(
        input logic             enabled,
        input logic [IDX_W-1:0] highest,
        input logic [UW-1:0]    lim
    );
        logic [UW-1:0] n;
        logic [UW-1:0] u;
        n = UW'(highest) + UW'(1);
        u = (n > lim) ? lim : n;
        return enabled ? CNT_W'(u) : '0;
    endfunction

endpackage

// ===== rtl/tps_page_ram.sv =====
module tps_page_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  tps_pkg::ram_req_t req,
    output tps_pkg::ram_rsp_t rsp
);

    logic [tps_pkg::DATA_W-1:0] mem [tps_pkg::PAGES];
    logic [tps_pkg::PAGES-1:0]  valid_reg;
    logic [tps_pkg::DATA_W-1:0] rdata_reg;
    logic                       rvalid_reg;

    // data array, no reset: an entry without its valid bit reads as zero
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (req.en)
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[req.addr];
        end
    end

    assign rsp.valid = rvalid_reg;
    assign rsp.data  = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/tag_page_store.sv =====
// a request's result is registered in the read stage, then in the output register
// throughput: one request per cycle while the result side keeps up
// the page ram is written or read in the cycle the request is accepted
// reset clears the valid bits (page data reads as zero), high-water mark,
// configuration registers and handshake state at once; no clearing pass
module tag_page_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tps_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [tps_pkg::REF_W-1:0]         page_ref,
    input  logic [tps_pkg::DATA_W-1:0]        page_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic [tps_pkg::DATA_W-1:0]        read_data,
    output logic                              read_valid,
    output logic [tps_pkg::CNT_W-1:0]         page_count
);

    logic                       enabled_reg;
    logic [tps_pkg::REF_W-1:0]  origin_reg;
    logic [tps_pkg::CNT_W-1:0]  limit_reg;
    logic [tps_pkg::IDX_W-1:0]  highest_reg;
    logic [tps_pkg::IDX_W-1:0]  highest_next;

    logic                       s1_valid_reg;
    logic                       s1_ok_reg;
    logic                       s1_read_reg;
    logic [tps_pkg::CNT_W-1:0]  s1_count_reg;

    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [tps_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_rvalid_reg;
    logic [tps_pkg::CNT_W-1:0]  out_count_reg;

    logic                       cfg_wr;
    tps_pkg::reg_idx_t          reg_idx;
    logic                       in_acc;
    logic                       s1_move;
    logic [tps_pkg::UW-1:0]     lim;
    logic [tps_pkg::REF_W:0]    wr_diff;
    logic                       wr_ok;
    logic                       rd_ok;
    logic [tps_pkg::CNT_W-1:0]  used_now;
    logic [tps_pkg::IDX_W-1:0]  idx;
    tps_pkg::ram_req_t          ram_req;
    tps_pkg::ram_rsp_t          ram_rsp;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = tps_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            origin_reg  <= '0;
            limit_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                tps_pkg::REG_ENABLE: enabled_reg <= pwdata[0];
                tps_pkg::REG_ORIGIN: origin_reg  <= pwdata[tps_pkg::REF_W-1:0];
                tps_pkg::REG_LIMIT:  limit_reg   <= pwdata[tps_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tps_pkg::REG_ENABLE: prdata = {31'd0, enabled_reg};
            tps_pkg::REG_ORIGIN: prdata = {16'd0, origin_reg};
            tps_pkg::REG_LIMIT:  prdata = {23'd0, limit_reg};
            default:             prdata = '0;
        endcase
    end

    // request decode
    assign s1_move  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign lim      = tps_pkg::eff_limit(limit_reg);
    assign wr_diff  = {1'b0, page_ref} - {1'b0, origin_reg};
    assign wr_ok    = (action == tps_pkg::ACT_WRITE) && enabled_reg && (lim != '0)
                      && !wr_diff[tps_pkg::REF_W]
                      && (wr_diff[tps_pkg::REF_W-1:0] < tps_pkg::REF_W'(lim));
    assign used_now = tps_pkg::used_count(enabled_reg, highest_reg, lim);
    assign rd_ok    = (action == tps_pkg::ACT_READ)
                      && (page_ref < tps_pkg::REF_W'(used_now));
    assign idx      = wr_ok ? wr_diff[tps_pkg::IDX_W-1:0] : page_ref[tps_pkg::IDX_W-1:0];

    always_comb
    begin
        highest_next = highest_reg;
        if (in_acc && wr_ok && (idx > highest_reg))
        begin
            highest_next = idx;
        end
    end

    assign ram_req.en    = in_acc;
    assign ram_req.we    = wr_ok;
    assign ram_req.addr  = idx;
    assign ram_req.wdata = page_data;

    tps_page_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rsp   (ram_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            highest_reg <= highest_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ok_reg    <= wr_ok || rd_ok;
            s1_read_reg  <= rd_ok;
            s1_count_reg <= tps_pkg::used_count(enabled_reg, highest_next, lim);
        end
        if (s1_move)
        begin
            out_ok_reg     <= s1_ok_reg;
            out_data_reg   <= s1_read_reg ? ram_rsp.data : '0;
            out_rvalid_reg <= s1_read_reg && ram_rsp.valid;
            out_count_reg  <= s1_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = out_ok_reg;
    assign read_data  = out_data_reg;
    assign read_valid = out_rvalid_reg;
    assign page_count = out_count_reg;

    // checks
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted request did not reach the read stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("read stage moved without a result");

    a_rvalid_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_rvalid_reg || out_ok_reg))
        else $error("valid bit reported on a failed request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (tps_pkg::UW'(out_count_reg) <= tps_pkg::PAGES_U))
        else $error("page count above store size");

endmodule
